// ===== rtl/sie_pkg.sv =====
// Shared constants and types for the signed integer extractor.
// Used by sie_accum and signed_integer_extractor; depends on nothing.
package sie_pkg;

   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int NUMBER_W = 32;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   typedef struct packed {
      logic overflowed;
      logic has_number;
   } rsp_user_type;

   typedef struct packed {
      logic start;
      logic negative;
   } acc_ctl_type;

endpackage

// ===== rtl/sie_accum.sv =====
// Decimal digit accumulator with saturation for the signed integer extractor.
// Computes the next run magnitude from the current one and a digit.
// Depends on sie_pkg.
module sie_accum #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic [VALUE_WIDTH-1:0]      acc_i,
   input  logic [sie_pkg::DIGIT_W-1:0] digit_i,
   input  sie_pkg::acc_ctl_type        ctl_i,
   output logic [VALUE_WIDTH-1:0]      acc_o,
   output logic                        sat_o,
   output logic [VALUE_WIDTH-1:0]      limit_o
);

   localparam int SUM_W = VALUE_WIDTH + 4;

   logic [VALUE_WIDTH-1:0] half;
   logic [SUM_W-1:0]       acc_ext;
   logic [SUM_W-1:0]       sum;
   logic                   over;

   assign half    = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   assign limit_o = ctl_i.negative ? half : half - VALUE_WIDTH'(1);

   // Times ten is eight times plus two times.
   assign acc_ext = SUM_W'(acc_i);
   assign sum     = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(digit_i);
   assign over    = sum > SUM_W'(limit_o);

   always_comb begin
      if (ctl_i.start) begin
         acc_o = VALUE_WIDTH'(digit_i);
         sat_o = 1'b0;
      end else if (over) begin
         acc_o = limit_o;
         sat_o = 1'b1;
      end else begin
         acc_o = sum[VALUE_WIDTH-1:0];
         sat_o = 1'b0;
      end
   end

endmodule

// ===== rtl/signed_integer_extractor.sv =====
// Signed integer extractor, top level: scans characters and emits decimal numbers.
// Depends on sie_pkg and sie_accum.
//
// The request channel carries one character per request in req_tdata, with
// req_tlast marking the final character of a string. Every maximal run of
// decimal digits becomes a signed number; a minus sign directly before the
// run makes it negative. A response carries the number in rsp_tdata, with
// rsp_tuser[0] set when a number is present and rsp_tuser[1] set when its
// magnitude saturated. rsp_tlast marks the response caused by the last
// character; that response may carry no number.
// A request is accepted in every cycle in which the response register is
// empty or is being drained, so one character per cycle is sustained. A
// response appears in the cycle after the request that causes it, from a
// single stage of logic between the run state and the response register.
// When the receiver stalls, the response holds and req_tready drops until
// it is taken. Reset clears the run state and empties the response register.
module signed_integer_extractor #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] number_value
   output logic [1:0]  rsp_tuser,   // [0] has_number, [1] overflowed
   output logic        rsp_tlast
);

   localparam int EXT_W = (VALUE_WIDTH > sie_pkg::NUMBER_W) ? VALUE_WIDTH : sie_pkg::NUMBER_W;

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   in_run_ff, in_run_in;
   logic                   neg_ff, neg_in;
   logic                   minus_ff, minus_in;
   logic                   ovf_ff, ovf_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sie_pkg::NUMBER_W-1:0] rsp_data_ff, rsp_data_in;
   sie_pkg::rsp_user_type        rsp_user_ff, rsp_user_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                          accept;
   logic                          is_digit;
   logic                          emit;
   sie_pkg::acc_ctl_type          acc_ctl;
   logic [VALUE_WIDTH-1:0]        acc_next;
   logic                          acc_sat;
   logic [VALUE_WIDTH-1:0]        acc_limit;
   logic                          run_neg;
   logic                          run_ovf;
   logic [VALUE_WIDTH-1:0]        run_acc;
   logic signed [VALUE_WIDTH-1:0] value_signed;
   logic signed [EXT_W-1:0]       value_wide;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_digit   = (req_tdata >= sie_pkg::CH_ZERO) && (req_tdata <= sie_pkg::CH_NINE);

   assign acc_ctl.start    = !in_run_ff;
   assign acc_ctl.negative = in_run_ff ? neg_ff : minus_ff;

   sie_accum #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_accum (
      .acc_i  (acc_ff),
      .digit_i(req_tdata[sie_pkg::DIGIT_W-1:0]),
      .ctl_i  (acc_ctl),
      .acc_o  (acc_next),
      .sat_o  (acc_sat),
      .limit_o(acc_limit)
   );

   // The run as it stands after this character.
   assign run_acc = is_digit ? acc_next : acc_ff;
   assign run_neg = is_digit ? acc_ctl.negative : neg_ff;
   assign run_ovf = is_digit ? (acc_sat || (in_run_ff && ovf_ff)) : ovf_ff;
   assign emit    = is_digit ? req_tlast : in_run_ff;

   assign value_signed = run_neg ? $signed(-run_acc) : $signed(run_acc);
   assign value_wide   = EXT_W'(value_signed);

   always_comb begin
      acc_in       = acc_ff;
      in_run_in    = in_run_ff;
      neg_in       = neg_ff;
      minus_in     = minus_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         acc_in    = run_acc;
         in_run_in = in_run_ff || is_digit;
         neg_in    = run_neg;
         ovf_in    = run_ovf;
         minus_in  = (req_tdata == sie_pkg::CH_MINUS);
         if (emit) begin
            rsp_valid_in           = 1'b1;
            rsp_data_in            = value_wide[sie_pkg::NUMBER_W-1:0];
            rsp_user_in.has_number = 1'b1;
            rsp_user_in.overflowed = run_ovf;
            rsp_last_in            = req_tlast;
            acc_in                 = '0;
            in_run_in              = 1'b0;
            neg_in                 = 1'b0;
            ovf_in                 = 1'b0;
         end else if (req_tlast) begin
            rsp_valid_in           = 1'b1;
            rsp_data_in            = '0;
            rsp_user_in.has_number = 1'b0;
            rsp_user_in.overflowed = 1'b0;
            rsp_last_in            = 1'b1;
         end
         if (req_tlast) begin
            acc_in    = '0;
            in_run_in = 1'b0;
            neg_in    = 1'b0;
            ovf_in    = 1'b0;
            minus_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         in_run_ff    <= 1'b0;
         neg_ff       <= 1'b0;
         minus_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         in_run_ff    <= in_run_in;
         neg_ff       <= neg_in;
         minus_ff     <= minus_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_ovf_has_number: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("overflow flag on a response without a number");

   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == '0))
      else $error("response without a number that is not a clean string end");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !in_run_ff && !minus_ff && !ovf_ff && (acc_ff == '0))
      else $error("run state not cleared after the last character");

   a_run_end_emits: assert property (@(posedge clock) disable iff (reset)
      accept && in_run_ff && !is_digit |=> rsp_tvalid && rsp_tuser[0])
      else $error("digit run ended without a number response");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      in_run_ff && ovf_ff |-> (acc_ff == acc_limit))
      else $error("saturated run not held at its limit");

endmodule

// ===== tb/tb_signed_integer_extractor.sv =====
// Self-checking testbench for signed_integer_extractor: character strings in, numbers out.
// Depends on sie_pkg and the signed_integer_extractor RTL; a scoreboard class predicts
// every response from the accepted requests.
`timescale 1ns / 100ps

typedef struct {
   logic [31:0] value;
   bit          has_number;
   bit          overflowed;
   bit          string_end;
} number_result_type;

class number_scoreboard;
   int unsigned       value_w;
   bit [63:0]         magnitude;
   bit                in_run;
   bit                run_neg;
   bit                prev_minus;
   bit                run_ovf;
   number_result_type pending_numbers[$];
   int                error_count;
   int                response_count;

   function new(int unsigned width);
      value_w        = width;
      error_count    = 0;
      response_count = 0;
      clear_run();
   endfunction

   function void clear_run();
      magnitude  = 64'd0;
      in_run     = 1'b0;
      run_neg    = 1'b0;
      prev_minus = 1'b0;
      run_ovf    = 1'b0;
   endfunction

   function int pending_count();
      return pending_numbers.size();
   endfunction

   function void note_char(bit [7:0] c, bit last);
      bit [63:0]         digit_val;
      bit [63:0]         limit;
      bit [63:0]         word;
      bit                is_digit;
      bit                emit;
      number_result_type r;
      is_digit = (c >= sie_pkg::CH_ZERO) && (c <= sie_pkg::CH_NINE);
      emit = 1'b0;
      if (is_digit) begin
         digit_val = {56'd0, c - sie_pkg::CH_ZERO};
         if (!in_run) begin
            in_run    = 1'b1;
            run_neg   = prev_minus;
            run_ovf   = 1'b0;
            magnitude = digit_val;
         end else begin
            limit = (64'd1 << (value_w - 1)) - (run_neg ? 64'd0 : 64'd1);
            if (digit_val > limit || magnitude > (limit - digit_val) / 64'd10) begin
               magnitude = limit;
               run_ovf   = 1'b1;
            end else begin
               magnitude = magnitude * 64'd10 + digit_val;
            end
         end
         if (last) emit = 1'b1;
      end else if (in_run) begin
         emit = 1'b1;
      end
      if (emit) begin
         word         = run_neg ? (~magnitude + 64'd1) : magnitude;
         r.value      = word[31:0];
         r.has_number = 1'b1;
         r.overflowed = run_ovf;
         r.string_end = last;
         pending_numbers.push_back(r);
         magnitude = 64'd0;
         in_run    = 1'b0;
         run_neg   = 1'b0;
         run_ovf   = 1'b0;
      end else if (last) begin
         r.value      = 32'd0;
         r.has_number = 1'b0;
         r.overflowed = 1'b0;
         r.string_end = 1'b1;
         pending_numbers.push_back(r);
      end
      prev_minus = (c == sie_pkg::CH_MINUS);
      if (last) clear_run();
   endfunction

   task report_mismatch(string msg);
      error_count++;
      $display("MISMATCH at %0t, response %0d: %s", $realtime, response_count, msg);
   endtask

   task check_response(logic [31:0] value, sie_pkg::rsp_user_type user, logic last);
      number_result_type want;
      response_count++;
      if (pending_numbers.size() == 0) begin
         report_mismatch($sformatf("unexpected response value %h has_number %b last %b",
                                   value, user.has_number, last));
         return;
      end
      want = pending_numbers.pop_front();
      if (value !== want.value)
         report_mismatch($sformatf("number_value %h, expected %h", value, want.value));
      if (user.has_number !== want.has_number)
         report_mismatch($sformatf("has_number %b, expected %b", user.has_number,
                                   want.has_number));
      if (user.overflowed !== want.overflowed)
         report_mismatch($sformatf("overflowed %b, expected %b", user.overflowed,
                                   want.overflowed));
      if (last !== want.string_end)
         report_mismatch($sformatf("string_end %b, expected %b", last, want.string_end));
   endtask
endclass

module tb_signed_integer_extractor;
   localparam int VALUE_W = 32;
   localparam int PHASE_CHARS = 325;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   number_scoreboard sb = new(VALUE_W);
   bit [7:0]         text_q[$];
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               chars_sent = 0;

   signed_integer_extractor #(.VALUE_WIDTH(VALUE_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   initial begin
      #2000000;
      $display("signed_integer_extractor test failed");
      $finish;
   end

   task send_char(bit [7:0] c, bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = c;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      chars_sent++;
   endtask

   task send_text();
      int i;
      for (i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task push_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task push_separator();
      bit [7:0] c;
      case ($urandom_range(9))
         0, 1, 2: c = sie_pkg::CH_MINUS;
         3:       c = 8'h00;
         4:       c = 8'hFF;
         default: begin
            do c = 8'($urandom_range(255));
            while (c >= sie_pkg::CH_ZERO && c <= sie_pkg::CH_NINE);
         end
      endcase
      text_q.push_back(c);
   endtask

   task push_number();
      longint unsigned mag;
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 12)) text_q.push_back(sie_pkg::CH_ZERO);
      case ($urandom_range(9))
         0, 1, 2, 3: mag = $urandom_range(99);
         4:          mag = $urandom_range(99999);
         5:          mag = $urandom;
         6:          mag = 64'd2147483645 + $urandom_range(6);
         7:          mag = 64'd4294967290 + $urandom_range(10);
         8:          mag = {$urandom, $urandom};
         default:    mag = $urandom_range(9);
      endcase
      push_text($sformatf("%0d", mag));
   endtask

   task build_random_text();
      int tokens;
      int i;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 16)) begin
            if ($urandom_range(1))
               text_q.push_back(8'(sie_pkg::CH_ZERO + $urandom_range(9)));
            else
               text_q.push_back(8'($urandom_range(255)));
         end
      end else begin
         tokens = $urandom_range(1, 4);
         for (i = 0; i < tokens; i++) begin
            if (i > 0 || $urandom_range(1)) repeat ($urandom_range(1, 3)) push_separator();
            if ($urandom_range(1)) text_q.push_back(sie_pkg::CH_MINUS);
            push_number();
         end
         if ($urandom_range(1)) repeat ($urandom_range(1, 2)) push_separator();
      end
   endtask

   task wait_drained();
      while (sb.pending_count() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task run_phase(int idle_pct, int stall_pct);
      int start_count;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start_count    = chars_sent;
      while (chars_sent - start_count < PHASE_CHARS) begin
         build_random_text();
         send_text();
      end
      req_tvalid = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Extreme codes, a minus chain, a number cut short by the string end.
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      push_text("--12,9");
      send_text();
      // A minus at the end of one string must not make the next run negative.
      push_text("-");
      send_text();
      push_text("4x");
      send_text();
      push_text("-2147483649");
      send_text();
      push_text("7");
      send_text();
      req_tvalid = 1'b0;
      wait_drained();

      run_phase(0, 0);
      run_phase(69, 0);
      run_phase(0, 69);
      run_phase(32, 32);

      repeat (10) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_count() == 0) begin
         $display("signed_integer_extractor test passed");
      end else begin
         $display("signed_integer_extractor test failed");
      end
      $finish;
   end
endmodule
